// ===== design/sbpsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sliding-bar source address block.
// No dependencies; every other design file refers to this package by scoped names.
package sbpsa_pkg;

  localparam int unsigned MaxDim = 4096;
  localparam int unsigned DimW   = $clog2(MaxDim);      // coordinate / register width
  localparam int unsigned RowW   = DimW + 1;            // row + offset, col + offset
  localparam int unsigned AreaW  = 2 * DimW;            // width * height
  localparam int unsigned FullW  = RowW + DimW + 1;     // unmasked linear address
  localparam int unsigned AddrW  = 25;                  // delivered address field
  localparam int unsigned CntW   = $clog2(DimW);        // divider step counter

  // APB register file
  localparam int unsigned NumRegs = 7;
  localparam int unsigned PaddrW  = $clog2(NumRegs * 4);
  localparam int unsigned PdataW  = 32;
  localparam int unsigned IdxW    = PaddrW - 2;

  localparam logic [IdxW-1:0] RegFrameWidth  = IdxW'(0);
  localparam logic [IdxW-1:0] RegFrameHeight = IdxW'(1);
  localparam logic [IdxW-1:0] RegBandDivider = IdxW'(2);
  localparam logic [IdxW-1:0] RegTopHStep    = IdxW'(3);
  localparam logic [IdxW-1:0] RegBottomHStep = IdxW'(4);
  localparam logic [IdxW-1:0] RegTopVStep    = IdxW'(5);
  localparam logic [IdxW-1:0] RegBottomVStep = IdxW'(6);

  localparam logic [DimW-1:0] FrameWidthRst  = DimW'(640);
  localparam logic [DimW-1:0] FrameHeightRst = DimW'(480);
  localparam logic [DimW-1:0] BandDividerRst = DimW'(4);
  localparam logic [DimW-1:0] TopHStepRst    = DimW'(1);
  localparam logic [DimW-1:0] BottomHStepRst = DimW'(3);
  localparam logic [DimW-1:0] TopVStepRst    = DimW'(0);
  localparam logic [DimW-1:0] BottomVStepRst = DimW'(0);

  // Stream opcodes
  localparam logic OpPixel    = 1'b0;
  localparam logic OpFrameEnd = 1'b1;

  typedef struct packed {
    logic [DimW-1:0] frame_width;
    logic [DimW-1:0] frame_height;
    logic [DimW-1:0] band_divider;
    logic [DimW-1:0] top_h_step;
    logic [DimW-1:0] bottom_h_step;
    logic [DimW-1:0] top_v_step;
    logic [DimW-1:0] bottom_v_step;
  } cfg_t;

  // Band geometry derived once per configuration
  typedef struct packed {
    logic [DimW-1:0] band_rows;
    logic [DimW-1:0] band_start;   // also the vertical offset limit
  } geom_t;

  // Payload between the select stage and the address stage
  typedef struct packed {
    logic            take;
    logic [RowW-1:0] row;
    logic [RowW-1:0] col;
  } mid_t;

  typedef struct packed {
    logic [DimW-1:0] off;
    logic [DimW-1:0] next;
  } ofs_t;

  // Offset in use this frame and the accumulator value after a frame end.
  function automatic ofs_t step_offset(logic [DimW-1:0] accum, logic [DimW-1:0] step,
                                       logic [DimW-1:0] limit);
    logic [RowW-1:0] sum;
    logic            wrap;
    ofs_t            res;
    sum      = {1'b0, accum} + {1'b0, step};
    wrap     = sum > {1'b0, limit};
    res.off  = wrap ? '0 : sum[DimW-1:0];
    res.next = wrap ? step : sum[DimW-1:0];
    return res;
  endfunction

endpackage

// ===== design/sbpsa_cfg.sv =====
`timescale 1ns / 1ps
// APB register file for the sliding-bar source address block, plus the frame area product.
// Depends on sbpsa_pkg.
module sbpsa_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbpsa_pkg::PaddrW-1:0]   paddr,
  input  logic [sbpsa_pkg::PdataW-1:0]   pwdata,
  output logic [sbpsa_pkg::PdataW-1:0]   prdata,
  output logic                           pready,
  output sbpsa_pkg::cfg_t                cfg_o,
  output logic [sbpsa_pkg::AreaW-1:0]    area_o,
  output logic                           wr_o
);

  sbpsa_pkg::cfg_t                    cfg_q;
  logic [sbpsa_pkg::AreaW-1:0]        area_q;
  logic [sbpsa_pkg::IdxW-1:0]         idx;
  logic [sbpsa_pkg::DimW-1:0]         wval;
  logic [sbpsa_pkg::DimW-1:0]         rval;
  logic                               wr;

  assign idx    = paddr[sbpsa_pkg::PaddrW-1:2];
  assign wval   = pwdata[sbpsa_pkg::DimW-1:0];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= sbpsa_pkg::FrameWidthRst;
      cfg_q.frame_height  <= sbpsa_pkg::FrameHeightRst;
      cfg_q.band_divider  <= sbpsa_pkg::BandDividerRst;
      cfg_q.top_h_step    <= sbpsa_pkg::TopHStepRst;
      cfg_q.bottom_h_step <= sbpsa_pkg::BottomHStepRst;
      cfg_q.top_v_step    <= sbpsa_pkg::TopVStepRst;
      cfg_q.bottom_v_step <= sbpsa_pkg::BottomVStepRst;
    end else if (wr) begin
      unique case (idx)
        sbpsa_pkg::RegFrameWidth:  cfg_q.frame_width   <= wval;
        sbpsa_pkg::RegFrameHeight: cfg_q.frame_height  <= wval;
        sbpsa_pkg::RegBandDivider: cfg_q.band_divider  <= wval;
        sbpsa_pkg::RegTopHStep:    cfg_q.top_h_step    <= wval;
        sbpsa_pkg::RegBottomHStep: cfg_q.bottom_h_step <= wval;
        sbpsa_pkg::RegTopVStep:    cfg_q.top_v_step    <= wval;
        sbpsa_pkg::RegBottomVStep: cfg_q.bottom_v_step <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sbpsa_pkg::RegFrameWidth:  rval = cfg_q.frame_width;
      sbpsa_pkg::RegFrameHeight: rval = cfg_q.frame_height;
      sbpsa_pkg::RegBandDivider: rval = cfg_q.band_divider;
      sbpsa_pkg::RegTopHStep:    rval = cfg_q.top_h_step;
      sbpsa_pkg::RegBottomHStep: rval = cfg_q.bottom_h_step;
      sbpsa_pkg::RegTopVStep:    rval = cfg_q.top_v_step;
      sbpsa_pkg::RegBottomVStep: rval = cfg_q.bottom_v_step;
      default:                   rval = '0;
    endcase
  end

  assign prdata = sbpsa_pkg::PdataW'(rval);

  // Area is registered from the width and height registers; the divider pass covers that delay.
  always_ff @(posedge clk_i) begin
    area_q <= sbpsa_pkg::AreaW'(cfg_q.frame_width) * sbpsa_pkg::AreaW'(cfg_q.frame_height);
  end

  assign cfg_o  = cfg_q;
  assign area_o = area_q;
  assign wr_o   = wr;

endmodule

// ===== design/sbpsa_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider: band rows = frame height / band divider, one bit a cycle.
// Depends on sbpsa_pkg.
module sbpsa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic [sbpsa_pkg::DimW-1:0]  frame_height_i,
  input  logic [sbpsa_pkg::DimW-1:0]  band_divider_i,
  output sbpsa_pkg::geom_t            geom_o,
  output logic                        busy_o
);

  logic                          pending_q;
  logic                          busy_q;
  logic [sbpsa_pkg::CntW-1:0]    cnt_q;
  logic [sbpsa_pkg::RowW-1:0]    rem_q;
  logic [sbpsa_pkg::DimW-1:0]    quo_q;
  sbpsa_pkg::geom_t              geom_q;

  logic [sbpsa_pkg::RowW-1:0]    dvs;
  logic [sbpsa_pkg::RowW-1:0]    rem_sh;
  logic                          ge;
  logic [sbpsa_pkg::RowW-1:0]    rem_n;
  logic [sbpsa_pkg::DimW-1:0]    quo_n;

  // A zero divider divides by one
  assign dvs    = (band_divider_i == '0) ? sbpsa_pkg::RowW'(1) : {1'b0, band_divider_i};
  assign rem_sh = {rem_q[sbpsa_pkg::DimW-1:0], quo_q[sbpsa_pkg::DimW-1]};
  assign ge     = rem_sh >= dvs;
  assign rem_n  = ge ? rem_sh - dvs : rem_sh;
  assign quo_n  = {quo_q[sbpsa_pkg::DimW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b1;
      busy_q    <= 1'b0;
      cnt_q     <= '0;
    end else if (restart_i) begin
      pending_q <= 1'b1;
      busy_q    <= 1'b0;
    end else if (pending_q) begin
      pending_q <= 1'b0;
      busy_q    <= 1'b1;
      cnt_q     <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == sbpsa_pkg::CntW'(sbpsa_pkg::DimW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pending_q) begin
      rem_q <= '0;
      quo_q <= frame_height_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (cnt_q == sbpsa_pkg::CntW'(sbpsa_pkg::DimW - 1)) begin
        geom_q.band_rows  <= quo_n;
        geom_q.band_start <= frame_height_i - quo_n;
      end
    end
  end

  assign geom_o = geom_q;
  assign busy_o = pending_q | busy_q;

endmodule

// ===== design/sbpsa_sel.sv =====
`timescale 1ns / 1ps
// Band select stage: offset accumulators, band decode, row and column sums into a register.
// Depends on sbpsa_pkg.
module sbpsa_sel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        op_i,
  input  logic [sbpsa_pkg::DimW-1:0]  px_i,
  input  logic [sbpsa_pkg::DimW-1:0]  py_i,
  input  sbpsa_pkg::cfg_t             cfg_i,
  input  sbpsa_pkg::geom_t            geom_i,
  output sbpsa_pkg::mid_t             mid_o
);

  logic [sbpsa_pkg::DimW-1:0]  top_h_acc_q, bot_h_acc_q, top_v_acc_q, bot_v_acc_q;
  sbpsa_pkg::ofs_t             top_h, bot_h, top_v, bot_v;
  logic                        in_frame, in_top, in_bottom;
  logic [sbpsa_pkg::DimW-1:0]  hoff, voff;
  logic [sbpsa_pkg::RowW-1:0]  r;
  sbpsa_pkg::mid_t             mid_d, mid_q;

  assign top_h = sbpsa_pkg::step_offset(top_h_acc_q, cfg_i.top_h_step, cfg_i.frame_width);
  assign bot_h = sbpsa_pkg::step_offset(bot_h_acc_q, cfg_i.bottom_h_step, cfg_i.frame_width);
  assign top_v = sbpsa_pkg::step_offset(top_v_acc_q, cfg_i.top_v_step, geom_i.band_start);
  assign bot_v = sbpsa_pkg::step_offset(bot_v_acc_q, cfg_i.bottom_v_step, geom_i.band_start);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_h_acc_q <= '0;
      bot_h_acc_q <= '0;
      top_v_acc_q <= '0;
      bot_v_acc_q <= '0;
    end else if (adv_i && (op_i == sbpsa_pkg::OpFrameEnd)) begin
      top_h_acc_q <= top_h.next;
      bot_h_acc_q <= bot_h.next;
      top_v_acc_q <= top_v.next;
      bot_v_acc_q <= bot_v.next;
    end
  end

  assign in_frame  = (px_i < cfg_i.frame_width) && (py_i < cfg_i.frame_height);
  assign in_bottom = py_i >= geom_i.band_start;
  assign in_top    = py_i < geom_i.band_rows;

  // Bottom band wins the overlap
  always_comb begin
    if (in_bottom) begin
      r    = sbpsa_pkg::RowW'(py_i - geom_i.band_start) + 1'b1;
      hoff = bot_h.off;
      voff = bot_v.off;
    end else begin
      r    = {1'b0, py_i};
      hoff = top_h.off;
      voff = top_v.off;
    end
    mid_d.take = (op_i == sbpsa_pkg::OpPixel) && in_frame && (in_bottom || in_top);
    mid_d.row  = r + {1'b0, voff};
    mid_d.col  = {1'b0, px_i} + {1'b0, hoff};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

// ===== design/sbpsa_addr.sv =====
`timescale 1ns / 1ps
// Address stage: row * width + column, bounds compare, into the output register.
// Depends on sbpsa_pkg.
module sbpsa_addr (
  input  logic                         clk_i,
  input  logic                         adv_i,
  input  sbpsa_pkg::mid_t              mid_i,
  input  logic [sbpsa_pkg::DimW-1:0]   frame_width_i,
  input  logic [sbpsa_pkg::AreaW-1:0]  area_i,
  output logic                         take_o,
  output logic [sbpsa_pkg::AddrW-1:0]  addr_o,
  output logic                         oof_o
);

  logic [sbpsa_pkg::FullW-1:0]  full;
  logic                         take_q, oof_q;
  logic [sbpsa_pkg::AddrW-1:0]  addr_q;

  assign full = sbpsa_pkg::FullW'(mid_i.row) * sbpsa_pkg::FullW'(frame_width_i)
              + sbpsa_pkg::FullW'(mid_i.col);

  // Frame-end and rejected pixels deliver all zeros
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      take_q <= mid_i.take;
      addr_q <= mid_i.take ? full[sbpsa_pkg::AddrW-1:0] : '0;
      oof_q  <= mid_i.take && (full >= sbpsa_pkg::FullW'(area_i));
    end
  end

  assign take_o = take_q;
  assign addr_o = addr_q;
  assign oof_o  = oof_q;

endmodule

// ===== design/sliding_bar_pixel_source_address.sv =====
`timescale 1ns / 1ps
// Top level of the sliding-bar transition source address generator.
// Depends on sbpsa_pkg, sbpsa_cfg, sbpsa_div, sbpsa_sel and sbpsa_addr.
//
// Channel   Dir  Handshake                Payload
// s_axis    in   tvalid / tready          tuser: op; tdata: pixel_x, pixel_y
// m_axis    out  tvalid / tready          tuser: take_second, out_of_frame;
//                                         tdata: source_address
// apb       in   psel/penable/pwrite/pready  7 registers of 12 bits at 4*i
//
// Each transaction passes three registers (input, band select, address) before its result
// appears on m_axis; one transaction per cycle sustained while m_axis_tready stays high.
// After reset and after every register write the band-height divider runs a pass
// (load plus 12 quotient bits); s_axis_tready stays low during that pass.
// Each stage advances when the stage after it is empty or moving, so bubbles close
// up and new transactions enter while a finished result waits on m_axis_tready.
module sliding_bar_pixel_source_address (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
  input  logic                          s_axis_tuser,   // [0] op
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [24:0] source_address, rest zero
  output logic [1:0]                    m_axis_tuser,   // [0] take_second, [1] out_of_frame
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbpsa_pkg::PaddrW-1:0]  paddr,
  input  logic [sbpsa_pkg::PdataW-1:0]  pwdata,
  output logic [sbpsa_pkg::PdataW-1:0]  prdata,
  output logic                          pready
);

  sbpsa_pkg::cfg_t                cfg;
  sbpsa_pkg::geom_t               geom;
  sbpsa_pkg::mid_t                mid;
  logic [sbpsa_pkg::AreaW-1:0]    area;
  logic                           cfg_wr;
  logic                           div_busy;

  logic                           v0_q, v1_q, v2_q;
  logic                           op0_q;
  logic [sbpsa_pkg::DimW-1:0]     px0_q, py0_q;
  logic                           rdy0, rdy1, rdy2;
  logic                           adv0, adv1, acc;

  logic                           take;
  logic [sbpsa_pkg::AddrW-1:0]    addr;
  logic                           oof;

  sbpsa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .area_o  (area),
    .wr_o    (cfg_wr)
  );

  // Recompute band geometry after every write
  sbpsa_div u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (cfg_wr),
    .frame_height_i (cfg.frame_height),
    .band_divider_i (cfg.band_divider),
    .geom_o         (geom),
    .busy_o         (div_busy)
  );

  // Stage handshake: each stage moves when the next one is free or moving
  assign rdy2 = !v2_q || m_axis_tready;
  assign adv1 = v1_q && rdy2;
  assign rdy1 = !v1_q || rdy2;
  assign adv0 = v0_q && rdy1;
  assign rdy0 = !v0_q || rdy1;

  assign s_axis_tready = rdy0 && !div_busy;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= acc || (v0_q && !adv0);
      v1_q <= adv0 || (v1_q && !adv1);
      v2_q <= adv1 || (v2_q && !m_axis_tready);
    end
  end

  // Input register: hold the transaction until the select stage takes it
  always_ff @(posedge clk_i) begin
    if (acc) begin
      op0_q <= s_axis_tuser;
      px0_q <= s_axis_tdata[sbpsa_pkg::DimW-1:0];
      py0_q <= s_axis_tdata[2*sbpsa_pkg::DimW-1:sbpsa_pkg::DimW];
    end
  end

  // Accumulators advance as the frame-end transaction leaves the input register
  sbpsa_sel u_sel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv0),
    .op_i   (op0_q),
    .px_i   (px0_q),
    .py_i   (py0_q),
    .cfg_i  (cfg),
    .geom_i (geom),
    .mid_o  (mid)
  );

  sbpsa_addr u_addr (
    .clk_i         (clk_i),
    .adv_i         (adv1),
    .mid_i         (mid),
    .frame_width_i (cfg.frame_width),
    .area_i        (area),
    .take_o        (take),
    .addr_o        (addr),
    .oof_o         (oof)
  );

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = 32'(addr);
  assign m_axis_tuser  = {oof, take};

  // Out of frame is only ever flagged on a pixel taken from frame B
  a_oof_implies_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
    else $error("out_of_frame set without take_second");

  // Band geometry is consistent whenever transactions may enter
  a_geom_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !div_busy |-> (geom.band_rows <= cfg.frame_height) &&
                  (geom.band_start == cfg.frame_height - geom.band_rows))
    else $error("band geometry inconsistent with frame height");

  // A stalled result register never loses its transaction
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !m_axis_tready) |=> v2_q)
    else $error("pending result dropped");

  // A transaction that leaves the input register always fills the select stage
  a_adv_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv0 |=> v1_q)
    else $error("select stage lost a transaction");

endmodule

// ===== tb/sv/tb_sliding_bar_pixel_source_address.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the sliding-bar source address generator: random and directed
// pixel/frame-end transactions, APB register phases, and a cycle-free predictor.
// Depends on sbpsa_pkg and sliding_bar_pixel_source_address.
module tb_sliding_bar_pixel_source_address;

  localparam int QuietLimit  = 2000;  // cycles with no transaction before giving up
  localparam int LongHold    = 300;   // receiver hold-off that backs the pipe up
  localparam int DrainCycles = 20;    // extra cycles after the last result
  localparam int PhaseItems  = 128;
  localparam int NumPhases   = 12;

  // One input transaction: tuser carries op, tdata carries {pixel_y, pixel_x}
  typedef struct packed {
    logic        op;
    logic [11:0] y;
    logic [11:0] x;
  } pixel_req_t;

  // One result transaction as the predictor sees it
  typedef struct packed {
    logic        take;
    logic [24:0] addr;
    logic        oof;
  } source_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [23:0]                    s_axis_tdata = '0;   // [11:0] pixel_x, [23:12] pixel_y
  logic                           s_axis_tuser = 1'b0; // [0] op
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [31:0]                    m_axis_tdata;        // [24:0] source_address
  logic [1:0]                     m_axis_tuser;        // [0] take_second, [1] out_of_frame
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [sbpsa_pkg::PaddrW-1:0]   paddr = '0;
  logic [sbpsa_pkg::PdataW-1:0]   pwdata = '0;
  logic [sbpsa_pkg::PdataW-1:0]   prdata;
  logic                           pready;

  sliding_bar_pixel_source_address uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: register copy (reset values) and the four offset accumulators
  logic [11:0] cfg_shadow [sbpsa_pkg::NumRegs] =
    '{12'd640, 12'd480, 12'd4, 12'd1, 12'd3, 12'd0, 12'd0};
  logic [11:0] top_h_acc = '0;
  logic [11:0] bottom_h_acc = '0;
  logic [11:0] top_v_acc = '0;
  logic [11:0] bottom_v_acc = '0;

  pixel_req_t pending_requests [$];
  source_t    expected_sources [$];
  pixel_req_t offered;
  int         items_issued = 0;
  int         results_checked = 0;
  int         mismatches = 0;
  int         idle_style = 0;     // 0 none, 1 full random gaps, 2 occasional gaps
  int         stall_request = 0;  // bump to ask the receiver for one long hold-off
  int         stall_served = 0;
  int         tx_wait = 0;
  int         rx_wait = 0;
  int         quiet_cycles = 0;

  function automatic logic [11:0] clip12(int unsigned v);
    return (v > 4095) ? 12'hFFF : 12'(v);
  endfunction

  // Offset in use this frame: accumulator plus step, zero once past the limit
  function automatic logic [12:0] band_offset(logic [11:0] acc, logic [11:0] step,
                                              logic [11:0] limit);
    logic [12:0] sum;
    sum = {1'b0, acc} + {1'b0, step};
    return (sum > {1'b0, limit}) ? 13'd0 : sum;
  endfunction

  // Accumulator after a frame end: restart from zero past the limit, then add the step
  function automatic logic [11:0] advanced_acc(logic [11:0] acc, logic [11:0] step,
                                               logic [11:0] limit);
    logic [12:0] sum;
    sum = {1'b0, acc} + {1'b0, step};
    return (sum > {1'b0, limit}) ? step : sum[11:0];
  endfunction

  // Work out the result of one accepted transaction and advance state on frame end
  function automatic source_t source_lookup(pixel_req_t req);
    int unsigned fw, fh, div, rows, bstart, row, hoff, voff, addr;
    source_t     res;
    fw     = cfg_shadow[sbpsa_pkg::RegFrameWidth];
    fh     = cfg_shadow[sbpsa_pkg::RegFrameHeight];
    div    = (cfg_shadow[sbpsa_pkg::RegBandDivider] == 0) ? 1 :
             cfg_shadow[sbpsa_pkg::RegBandDivider];
    rows   = fh / div;
    bstart = fh - rows;  // also the vertical offset limit
    res    = '0;
    if (req.op == sbpsa_pkg::OpFrameEnd) begin
      top_h_acc    = advanced_acc(top_h_acc, cfg_shadow[sbpsa_pkg::RegTopHStep], 12'(fw));
      bottom_h_acc = advanced_acc(bottom_h_acc, cfg_shadow[sbpsa_pkg::RegBottomHStep],
                                  12'(fw));
      top_v_acc    = advanced_acc(top_v_acc, cfg_shadow[sbpsa_pkg::RegTopVStep],
                                  12'(bstart));
      bottom_v_acc = advanced_acc(bottom_v_acc, cfg_shadow[sbpsa_pkg::RegBottomVStep],
                                  12'(bstart));
      return res;
    end
    if (req.x < fw && req.y < fh && (req.y >= bstart || req.y < rows)) begin
      // bottom band wins where the two overlap
      if (req.y >= bstart) begin
        row  = req.y - bstart + 1;
        hoff = band_offset(bottom_h_acc, cfg_shadow[sbpsa_pkg::RegBottomHStep], 12'(fw));
        voff = band_offset(bottom_v_acc, cfg_shadow[sbpsa_pkg::RegBottomVStep],
                           12'(bstart));
      end else begin
        row  = req.y;
        hoff = band_offset(top_h_acc, cfg_shadow[sbpsa_pkg::RegTopHStep], 12'(fw));
        voff = band_offset(top_v_acc, cfg_shadow[sbpsa_pkg::RegTopVStep], 12'(bstart));
      end
      addr     = (row + voff) * fw + req.x + hoff;
      res.take = 1'b1;
      res.addr = addr[24:0];
      res.oof  = (addr >= fw * fh);
    end
    return res;
  endfunction

  function automatic int draw_wait();
    case (idle_style)
      0:       return 0;
      1:       return $urandom_range(0, 17);
      default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  // Random request aimed mostly at the bands and the frame edges of the current setting
  function automatic pixel_req_t draw_request();
    int unsigned fw, fh, div, rows, bstart, pick;
    pixel_req_t  req;
    fw     = cfg_shadow[sbpsa_pkg::RegFrameWidth];
    fh     = cfg_shadow[sbpsa_pkg::RegFrameHeight];
    div    = (cfg_shadow[sbpsa_pkg::RegBandDivider] == 0) ? 1 :
             cfg_shadow[sbpsa_pkg::RegBandDivider];
    rows   = fh / div;
    bstart = fh - rows;
    pick   = $urandom_range(0, 99);
    req.op = sbpsa_pkg::OpPixel;
    req.x  = 12'($urandom);
    req.y  = 12'($urandom);
    if (pick < 8) begin
      req.op = sbpsa_pkg::OpFrameEnd;
    end else if (pick >= 20) begin
      req.x = clip12($urandom_range(0, fw + 1));
      case (pick % 3)
        0:       req.y = clip12($urandom_range(0, rows + 1));
        1:       req.y = clip12($urandom_range((bstart > 0) ? bstart - 1 : 0, fh + 1));
        default: req.y = clip12($urandom_range(0, fh + 1));
      endcase
    end
    return req;
  endfunction

  function automatic logic [11:0] pick_step(int unsigned limit, int style);
    int unsigned roll;
    roll = $urandom_range(0, 5);
    if (style == 2 && roll < 3) begin
      return (roll == 0) ? 12'd0 : (roll == 1) ? 12'(limit) : 12'hFFF;
    end
    if (roll == 5) return 12'($urandom);
    return clip12($urandom_range(0, limit + 1));
  endfunction

  // Sender: offer pending transactions, hold tvalid until accepted, gap between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_sources.push_back(source_lookup(offered));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          offered = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= offered.op;
          s_axis_tdata  <= {offered.y, offered.x};
          tx_wait = draw_wait();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each result with the oldest expectation, stall at random
  always @(posedge clk_i) begin
    source_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sources.size() == 0) begin
          $display("%0t: result with no expectation waiting, tuser %b tdata %h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_sources.pop_front();
          results_checked++;
          if (m_axis_tuser[0] !== want.take) begin
            $display("%0t: take_second expected %0d actual %0d",
                     $time, want.take, m_axis_tuser[0]);
            mismatches++;
          end
          if (m_axis_tdata[24:0] !== want.addr) begin
            $display("%0t: source_address expected %0d actual %0d",
                     $time, want.addr, m_axis_tdata[24:0]);
            mismatches++;
          end
          if (m_axis_tuser[1] !== want.oof) begin
            $display("%0t: out_of_frame expected %0d actual %0d",
                     $time, want.oof, m_axis_tuser[1]);
            mismatches++;
          end
        end
        rx_wait = draw_wait();
      end
      // long hold-off so the pipe fills and s_axis_tready drops
      if (stall_request != stall_served) begin
        stall_served = stall_request;
        rx_wait = LongHold;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up once nothing has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_request(input pixel_req_t req);
    pending_requests.push_back(req);
    items_issued++;
  endtask

  task automatic queue_op(input logic op, input logic [11:0] x, input logic [11:0] y);
    pixel_req_t req;
    req.op = op;
    req.x  = x;
    req.y  = y;
    queue_request(req);
  endtask

  // Wait until every issued transaction has come back as a checked result
  task automatic settle();
    while (results_checked < items_issued) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_transfer(input logic wr, input logic [sbpsa_pkg::IdxW-1:0] idx,
                              input logic [11:0] wdata,
                              output logic [sbpsa_pkg::PdataW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= sbpsa_pkg::PdataW'(wdata);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, mirror it in the predictor and read it back
  task automatic program_reg(input logic [sbpsa_pkg::IdxW-1:0] idx,
                             input logic [11:0] value);
    logic [sbpsa_pkg::PdataW-1:0] rd;
    apb_transfer(1'b1, idx, value, rd);
    cfg_shadow[idx] = value;
    apb_transfer(1'b0, idx, 12'd0, rd);
    if (rd[11:0] !== value) begin
      $display("%0t: register %0d readback expected %0d actual %0d",
               $time, idx, value, rd[11:0]);
      mismatches++;
    end
  endtask

  // Program all seven registers; style 0 small, 1 any, 2 largest, 3 smallest frames
  task automatic pick_setting(input int style);
    int unsigned fw, fh, div, vlim;
    case (style)
      0: begin
        fw  = $urandom_range(1, 48);
        fh  = $urandom_range(1, 48);
        div = $urandom_range(1, 5);
      end
      1: begin
        fw  = $urandom_range(1, 4095);
        fh  = $urandom_range(1, 4095);
        div = $urandom_range(1, 8);
      end
      2: begin
        fw  = 4095;
        fh  = 4095;
        div = $urandom_range(1, 2);
      end
      default: begin
        fw  = 1;
        fh  = $urandom_range(1, 3);
        div = 1;
      end
    endcase
    vlim = fh - fh / div;
    program_reg(sbpsa_pkg::RegFrameWidth, 12'(fw));
    program_reg(sbpsa_pkg::RegFrameHeight, 12'(fh));
    program_reg(sbpsa_pkg::RegBandDivider, 12'(div));
    program_reg(sbpsa_pkg::RegTopHStep, pick_step(fw, style));
    program_reg(sbpsa_pkg::RegBottomHStep, pick_step(fw, style));
    program_reg(sbpsa_pkg::RegTopVStep, pick_step(vlim, style));
    program_reg(sbpsa_pkg::RegBottomVStep, pick_step(vlim, style));
  endtask

  // Frames of random pixels closed by frame ends, with the odd burst of frame ends
  task automatic run_phase(input int count);
    int burst;
    int k;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 49) == 0) begin
        burst = $urandom_range(4, 24);
        repeat (burst) queue_op(sbpsa_pkg::OpFrameEnd, 12'($urandom), 12'($urandom));
        k += burst;
      end else begin
        queue_request(draw_request());
        k++;
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: 640x480, bands of 120 rows at the top and from row 360 down
    queue_op(sbpsa_pkg::OpPixel, 12'd0, 12'd0);
    queue_op(sbpsa_pkg::OpPixel, 12'd639, 12'd0);
    queue_op(sbpsa_pkg::OpPixel, 12'd640, 12'd0);      // past the right edge
    queue_op(sbpsa_pkg::OpPixel, 12'hFFF, 12'hFFF);
    queue_op(sbpsa_pkg::OpPixel, 12'd0, 12'd119);      // last top-band row
    queue_op(sbpsa_pkg::OpPixel, 12'd0, 12'd120);      // between the bands: keep frame A
    queue_op(sbpsa_pkg::OpPixel, 12'd0, 12'd359);
    queue_op(sbpsa_pkg::OpPixel, 12'd0, 12'd360);      // first bottom-band row
    queue_op(sbpsa_pkg::OpPixel, 12'd639, 12'd479);
    queue_op(sbpsa_pkg::OpPixel, 12'd0, 12'd480);      // below the frame
    queue_op(sbpsa_pkg::OpFrameEnd, 12'hFFF, 12'hFFF); // all-zero result, offsets advance
    queue_op(sbpsa_pkg::OpPixel, 12'd5, 12'd5);
    queue_op(sbpsa_pkg::OpPixel, 12'd5, 12'd400);
    settle();

    // Tiny frame, both bands covering everything: bottom wins, steps at and past limits
    program_reg(sbpsa_pkg::RegFrameWidth, 12'd8);
    program_reg(sbpsa_pkg::RegFrameHeight, 12'd8);
    program_reg(sbpsa_pkg::RegBandDivider, 12'd1);
    program_reg(sbpsa_pkg::RegTopHStep, 12'd9);
    program_reg(sbpsa_pkg::RegBottomHStep, 12'd8);
    program_reg(sbpsa_pkg::RegTopVStep, 12'd0);
    program_reg(sbpsa_pkg::RegBottomVStep, 12'd1);
    queue_op(sbpsa_pkg::OpPixel, 12'd0, 12'd0);
    queue_op(sbpsa_pkg::OpPixel, 12'd7, 12'd7);
    queue_op(sbpsa_pkg::OpFrameEnd, 12'd0, 12'd0);
    queue_op(sbpsa_pkg::OpPixel, 12'd7, 12'd7);
    settle();
    // zero divider behaves as one
    program_reg(sbpsa_pkg::RegBandDivider, 12'd0);
    queue_op(sbpsa_pkg::OpPixel, 12'd2, 12'd2);
    settle();
    // divider above the height leaves empty bands
    program_reg(sbpsa_pkg::RegBandDivider, 12'hFFF);
    queue_op(sbpsa_pkg::OpPixel, 12'd1, 12'd1);
    settle();
    // zero width, then zero height: every pixel keeps frame A
    program_reg(sbpsa_pkg::RegFrameWidth, 12'd0);
    queue_op(sbpsa_pkg::OpPixel, 12'd0, 12'd0);
    settle();
    program_reg(sbpsa_pkg::RegFrameWidth, 12'd8);
    program_reg(sbpsa_pkg::RegFrameHeight, 12'd0);
    queue_op(sbpsa_pkg::OpPixel, 12'd0, 12'd0);
    queue_op(sbpsa_pkg::OpFrameEnd, 12'd0, 12'd0);

    // Random phases, each under a fresh setting and its own idling pattern
    for (phase = 0; phase < NumPhases; phase++) begin
      settle();
      idle_style = phase % 3;
      pick_setting(phase % 4);
      run_phase(PhaseItems);
      if (phase == 0) stall_request++;
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_sources.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
